// ----- rtl/jsrg_pkg.sv -----
// Shared constants, codes and types of the joint speed ramp generator.
package jsrg_pkg;

  localparam int SPEED_WIDTH_DEF = 32;
  localparam int MS_WIDTH        = 16;
  localparam int RATE_WIDTH      = 16;
  localparam int CMD_WIDTH       = 3;
  localparam int MODE_WIDTH      = 2;
  localparam int DIR_WIDTH       = 2;
  localparam int PROD_WIDTH      = MS_WIDTH + RATE_WIDTH;

  // Modes, as reported on mode_now
  localparam logic [MODE_WIDTH-1:0] MODE_STOP  = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_BRAKE = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_KEEP  = 2'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_ACCEL = 2'd3;

  // Action commands
  localparam logic [CMD_WIDTH-1:0] CMD_STOP       = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_BRAKE      = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_KEEP       = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_PUSH_FRONT = 3'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_PUSH_BACK  = 3'd4;

  // Push direction
  localparam logic [DIR_WIDTH-1:0] DIR_NONE  = 2'd0;
  localparam logic [DIR_WIDTH-1:0] DIR_FRONT = 2'd1;
  localparam logic [DIR_WIDTH-1:0] DIR_BACK  = 2'd3;

  localparam logic [RATE_WIDTH-1:0] BRAKE_RATE_RESET = 16'd100;

  typedef struct packed {
    logic [MODE_WIDTH-1:0] mode;
    logic [DIR_WIDTH-1:0]  dir;
    logic [RATE_WIDTH-1:0] rate;
  } ctrl_t;

endpackage

// ----- rtl/jsrg_if.sv -----
// Channel interfaces of the joint speed ramp generator: tick, result, config write.
interface jsrg_tick_if #(parameter int SPEED_WIDTH = jsrg_pkg::SPEED_WIDTH_DEF);
  import jsrg_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [MS_WIDTH-1:0]           elapsed_ms;
  logic signed [SPEED_WIDTH-1:0] speed_in;
  logic                          action_valid;
  logic [CMD_WIDTH-1:0]          command;
  logic                          accel_valid;
  logic [RATE_WIDTH-1:0]         accel_value;

  modport source (output valid, elapsed_ms, speed_in, action_valid, command,
                  accel_valid, accel_value, input ready);
  modport sink (input valid, elapsed_ms, speed_in, action_valid, command,
                accel_valid, accel_value, output ready);
endinterface

interface jsrg_result_if #(parameter int SPEED_WIDTH = jsrg_pkg::SPEED_WIDTH_DEF);
  import jsrg_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] speed_out;
  logic [MODE_WIDTH-1:0]         mode_now;
  logic                          saturated;

  modport source (output valid, speed_out, mode_now, saturated, input ready);
  modport sink (input valid, speed_out, mode_now, saturated, output ready);
endinterface

interface jsrg_cfg_if;
  import jsrg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [RATE_WIDTH-1:0] brake_rate;

  modport source (output valid, brake_rate, input ready);
  modport sink (input valid, brake_rate, output ready);
endinterface

// ----- rtl/jsrg_ctrl.sv -----
// Mode, push direction and acceleration state, updated once per item.
module jsrg_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic                            action_valid,
  input  logic [jsrg_pkg::CMD_WIDTH-1:0]  command,
  input  logic                            accel_valid,
  input  logic [jsrg_pkg::RATE_WIDTH-1:0] accel_value,
  output jsrg_pkg::ctrl_t                 ctrl_next
);
  import jsrg_pkg::*;

  logic [MODE_WIDTH-1:0] mode, mode_next;
  logic [DIR_WIDTH-1:0]  push_direction, push_direction_next;
  logic [RATE_WIDTH-1:0] accel_rate, accel_rate_next;

  always_comb begin
    mode_next           = mode;
    push_direction_next = push_direction;
    if (action_valid) begin
      unique case (command)
        CMD_STOP:  mode_next = MODE_STOP;
        CMD_BRAKE: mode_next = MODE_BRAKE;
        CMD_KEEP:  mode_next = MODE_KEEP;
        CMD_PUSH_FRONT: begin
          mode_next           = MODE_ACCEL;
          push_direction_next = DIR_FRONT;
        end
        CMD_PUSH_BACK: begin
          mode_next           = MODE_ACCEL;
          push_direction_next = DIR_BACK;
        end
        default: ;  // unknown code: hold mode and direction
      endcase
    end else begin
      mode_next = MODE_BRAKE;
    end
    accel_rate_next = accel_valid ? accel_value : accel_rate;
  end

  assign ctrl_next = '{mode: mode_next, dir: push_direction_next, rate: accel_rate_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_BRAKE;
      push_direction <= DIR_NONE;
      accel_rate     <= '0;
    end else if (fire) begin
      mode           <= mode_next;
      push_direction <= push_direction_next;
      accel_rate     <= accel_rate_next;
    end
  end

endmodule

// ----- rtl/jsrg_calc.sv -----
// Speed arithmetic for one tick: stop, brake toward zero, keep, or saturating accelerate.
module jsrg_calc #(
  parameter int SPEED_WIDTH = jsrg_pkg::SPEED_WIDTH_DEF
) (
  input  jsrg_pkg::ctrl_t                 ctrl,
  input  logic [jsrg_pkg::MS_WIDTH-1:0]   elapsed_ms,
  input  logic [jsrg_pkg::RATE_WIDTH-1:0] brake_rate,
  input  logic signed [SPEED_WIDTH-1:0]   speed_in,
  output logic signed [SPEED_WIDTH-1:0]   speed_out,
  output logic                            saturated
);
  import jsrg_pkg::*;

  localparam int EXT_WIDTH = ((SPEED_WIDTH > PROD_WIDTH) ? SPEED_WIDTH : PROD_WIDTH) + 2;

  logic [RATE_WIDTH-1:0]       rate_sel;
  logic [PROD_WIDTH-1:0]       prod;
  logic signed [EXT_WIDTH-1:0] speed_ext, prod_ext, mag, sum, max_ext, min_ext, result;

  // one shared multiplier: units/s times ms is thousandths directly
  assign rate_sel  = (ctrl.mode == MODE_ACCEL) ? ctrl.rate : brake_rate;
  assign prod      = rate_sel * elapsed_ms;
  assign speed_ext = EXT_WIDTH'(speed_in);
  assign prod_ext  = $signed(EXT_WIDTH'(prod));
  assign mag       = speed_ext[EXT_WIDTH-1] ? -speed_ext : speed_ext;
  assign max_ext   = $signed(EXT_WIDTH'({1'b0, {(SPEED_WIDTH-1){1'b1}}}));
  assign min_ext   = -max_ext - EXT_WIDTH'(1);

  always_comb begin
    saturated = 1'b0;
    sum       = speed_ext;
    result    = speed_ext;
    case (ctrl.mode)
      MODE_STOP:  result = '0;
      MODE_BRAKE: begin
        if (prod_ext < mag) begin
          result = speed_ext[EXT_WIDTH-1] ? speed_ext + prod_ext : speed_ext - prod_ext;
        end else begin
          result = '0;
        end
      end
      MODE_KEEP:  result = speed_ext;
      MODE_ACCEL: begin
        if (ctrl.dir == DIR_FRONT) begin
          sum = speed_ext + prod_ext;
        end else if (ctrl.dir == DIR_BACK) begin
          sum = speed_ext - prod_ext;
        end
        if (sum > max_ext) begin
          result    = max_ext;
          saturated = 1'b1;
        end else if (sum < min_ext) begin
          result    = min_ext;
          saturated = 1'b1;
        end else begin
          result = sum;
        end
      end
      default: result = speed_ext;
    endcase
  end

  assign speed_out = $signed(result[SPEED_WIDTH-1:0]);

endmodule

// ----- rtl/joint_speed_ramp_generator.sv -----
// A tick item waits in the input register, then moves into the result register.
// Throughput: one item per cycle unless result.ready is low; input and result
//   registers form a two-stage pipeline, so a free input register takes a tick
//   while a finished result waits.
// The mode/direction/rate state advances as an item moves into the result register.
// Reset (rst, synchronous): pipeline empty, mode brake, no push direction,
//   acceleration 0, brake_rate 100.
module joint_speed_ramp_generator #(
  parameter int SPEED_WIDTH = jsrg_pkg::SPEED_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  jsrg_tick_if.sink      tick,
  jsrg_result_if.source  result,
  jsrg_cfg_if.sink       cfg
);
  import jsrg_pkg::*;

  // Input register stage
  logic                          a_valid;
  logic [MS_WIDTH-1:0]           a_ms;
  logic signed [SPEED_WIDTH-1:0] a_speed;
  logic                          a_action_valid;
  logic [CMD_WIDTH-1:0]          a_command;
  logic                          a_accel_valid;
  logic [RATE_WIDTH-1:0]         a_accel_value;

  // Result register stage
  logic                          b_valid;
  logic signed [SPEED_WIDTH-1:0] b_speed;
  logic [MODE_WIDTH-1:0]         b_mode;
  logic                          b_sat;

  logic                          tick_accept;
  logic                          b_load;
  logic [RATE_WIDTH-1:0]         brake_rate;
  ctrl_t                         ctrl_next;
  logic signed [SPEED_WIDTH-1:0] calc_speed;
  logic                          calc_sat;

  // The result register takes a new item whenever it is empty or being drained,
  // and the input register refills in the same cycle it empties.
  assign b_load      = a_valid && (!b_valid || result.ready);
  assign tick.ready  = !a_valid || b_load;
  assign tick_accept = tick.valid && tick.ready;

  // Brake rate register, always ready; writes must arrive only while idle (not enforced here).
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brake_rate <= BRAKE_RATE_RESET;
    end else if (cfg.valid) begin
      brake_rate <= cfg.brake_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (tick_accept) begin
      a_valid <= 1'b1;
    end else if (b_load) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      a_ms           <= tick.elapsed_ms;
      a_speed        <= tick.speed_in;
      a_action_valid <= tick.action_valid;
      a_command      <= tick.command;
      a_accel_valid  <= tick.accel_valid;
      a_accel_value  <= tick.accel_value;
    end
  end

  // Mode decode and held state; committed when the item leaves the input stage.
  jsrg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .fire         (b_load),
    .action_valid (a_action_valid),
    .command      (a_command),
    .accel_valid  (a_accel_valid),
    .accel_value  (a_accel_value),
    .ctrl_next    (ctrl_next)
  );

  // One multiply, one add and a compare against the range limits.
  jsrg_calc #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_calc (
    .ctrl       (ctrl_next),
    .elapsed_ms (a_ms),
    .brake_rate (brake_rate),
    .speed_in   (a_speed),
    .speed_out  (calc_speed),
    .saturated  (calc_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= 1'b1;
    end else if (result.ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_speed <= calc_speed;
      b_mode  <= ctrl_next.mode;
      b_sat   <= calc_sat;
    end
  end

  assign result.valid     = b_valid;
  assign result.speed_out = b_speed;
  assign result.mode_now  = b_mode;
  assign result.saturated = b_sat;

`ifndef NO_ASSERTIONS
  // A waiting item moves on when the result register is empty.
  a_moves_on: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_valid |=> b_valid)
    else $error("input item not moved into empty result register");

  // Only the accelerate path can clip.
  sat_only_accel: assert property (@(posedge clk) disable iff (rst)
    b_valid && (b_mode != MODE_ACCEL) |-> !b_sat)
    else $error("saturated flag outside accelerate mode");

  // Stop mode always reports zero speed.
  stop_is_zero: assert property (@(posedge clk) disable iff (rst)
    b_valid && (b_mode == MODE_STOP) |-> (b_speed == '0))
    else $error("nonzero speed in stop mode");
`endif

endmodule
